### hdl/delimiter_stream_splitter_assert.svh
// Assertion macros for the delimiter stream splitter.
// Used by the RTL files that carry concurrent checks; needs no package.
`ifndef DELIMITER_STREAM_SPLITTER_ASSERT_SVH
`define DELIMITER_STREAM_SPLITTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dss_pkg.sv
// Shared types and constants for the delimiter stream splitter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dss_pkg;

  // Field widths fixed by the interface.
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 4;
  localparam int PAT_W     = 64;
  localparam int CFG_IDX_W = 2;

  // Default maximum delimiter length, in bytes (pattern holds at most 8).
  localparam int MAX_DELIM_DEF = 8;

  // Register reset values: three-byte start code 00 00 01.
  localparam logic [LEN_W-1:0] LEN_RESET = 4'd3;
  localparam logic [PAT_W-1:0] PAT_RESET = 64'h0000_0000_0001_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIM_LENGTH  = 2'd0,
    CFG_DELIM_PATTERN = 2'd1
  } cfg_idx_e;

  // Input item.
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_stream;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_last;
  } out_item_t;

  // Active delimiter setup; len is already clamped to the legal range.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pattern;
  } cfg_t;

  // Byte offered by the window toward the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } rel_t;

endpackage

### hdl/delimiter_stream_splitter.sv
// Top level of the delimiter stream splitter.
// Depends on dss_pkg, dss_cfg_regs, dss_window and dss_out_reg.
`timescale 1ns / 1ps

// Cuts a byte stream into frames on a delimiter of 1 to MaxDelim bytes
// (00 00 01 after reset). Each byte leaves in order with frame_last set on
// the byte just before a delimiter match, and on the final byte of a stream.
// Channels: input items (byte plus end_of_stream), result items (byte plus
// frame_last), and a configuration write port that is always ready.
// A byte is released once the delimiter-length bytes after it are held, and
// it reaches the result channel through the output register.
// Throughput is one item per cycle each way unless the receiver stalls or a
// flush runs; one spare window entry lets an item enter while another leaves.
// An end-of-stream item flushes every held byte, one per cycle unless stalled,
// and the input is not ready until the last has gone to the output register.
// Reset empties the window and loads the default delimiter; held bytes
// need no clearing. When the receiver stalls, the output register holds its
// item, the window fills, and the input drops ready once the window is full.

module delimiter_stream_splitter #(
  parameter int MaxDelim = dss_pkg::MAX_DELIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dss_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dss_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dss_pkg::PAT_W-1:0]     cfg_data_i
);
  import dss_pkg::*;

  cfg_t cfg;
  rel_t rel;
  logic rel_take;

  dss_cfg_regs #(
    .MaxDelim (MaxDelim)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dss_window #(
    .MaxDelim (MaxDelim)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg),
    .rel_take_i (rel_take),
    .rel_o      (rel)
  );

  dss_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rel_i       (rel),
    .rel_take_o  (rel_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### hdl/dss_cfg_regs.sv
// Configuration registers of the delimiter stream splitter.
// Depends on dss_pkg; produces the clamped delimiter setup.
`timescale 1ns / 1ps

module dss_cfg_regs #(
  parameter int MaxDelim = dss_pkg::MAX_DELIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dss_pkg::PAT_W-1:0]      cfg_data_i,
  output dss_pkg::cfg_t                  cfg_o
);
  import dss_pkg::*;

  logic [LEN_W-1:0] len_q, len_d;
  logic [PAT_W-1:0] pat_q, pat_d;

  // Writes are always taken; an unknown index changes nothing.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    len_d = len_q;
    pat_d = pat_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DELIM_LENGTH:  len_d = cfg_data_i[LEN_W-1:0];
        CFG_DELIM_PATTERN: pat_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
      pat_q <= PAT_RESET;
    end else begin
      len_q <= len_d;
      pat_q <= pat_d;
    end
  end

  // Zero acts as one byte, anything above the maximum as the maximum.
  always_comb begin
    cfg_o.pattern = pat_q;
    if (len_q == '0) begin
      cfg_o.len = LEN_W'(1);
    end else if (len_q > LEN_W'(MaxDelim)) begin
      cfg_o.len = LEN_W'(MaxDelim);
    end else begin
      cfg_o.len = len_q;
    end
  end

endmodule

### hdl/dss_window.sv
// Byte window of the delimiter stream splitter: holds bytes, matches the
// delimiter and releases the oldest byte with its mark. Depends on dss_pkg.
`timescale 1ns / 1ps
`include "delimiter_stream_splitter_assert.svh"

module dss_window #(
  parameter int MaxDelim = dss_pkg::MAX_DELIM_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dss_pkg::in_item_t in_item_i,
  input  dss_pkg::cfg_t     cfg_i,
  input  logic              rel_take_i,
  output dss_pkg::rel_t     rel_o
);
  import dss_pkg::*;

  // One spare entry beyond the delimiter plus one lets a byte enter while
  // another leaves, even at the longest delimiter.
  localparam int Depth = MaxDelim + 2;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int IdxW  = $clog2(Depth);

  logic [BYTE_W-1:0] win_q [Depth];
  logic [BYTE_W-1:0] win_d [Depth];
  logic [CntW-1:0]   count_q, count_d;
  logic              flush_q, flush_d;
  logic              armed_q, armed_d;

  logic [CntW-1:0]   len_c;
  logic [MaxDelim-1:0] hit;
  logic              matched;
  logic              rel_want;
  logic              release_c;
  logic              accept_c;
  logic [IdxW-1:0]   wr_idx;

  assign len_c = CntW'(cfg_i.len);

  // Delimiter compare against the bytes that follow the oldest one.
  always_comb begin
    for (int i = 0; i < MaxDelim; i++) begin
      hit[i] = (LEN_W'(i) >= cfg_i.len) ||
               (win_q[i+1] == cfg_i.pattern[BYTE_W*i +: BYTE_W]);
    end
  end
  assign matched = (count_q > len_c) && (&hit);

  // Release when more bytes than the delimiter length are held after an
  // item came in, or while an end of stream is being flushed.
  assign rel_want  = flush_q || (armed_q && (count_q > len_c));
  assign release_c = rel_want && rel_take_i;

  assign rel_o.valid           = rel_want;
  assign rel_o.item.out_byte   = win_q[0];
  assign rel_o.item.frame_last = matched || (flush_q && (count_q == CntW'(1)));

  // Input side depends on state only.
  assign in_ready_o = !flush_q && (count_q < CntW'(Depth));
  assign accept_c   = in_valid_i && in_ready_o;

  assign wr_idx = IdxW'(count_q - CntW'(release_c));

  // Window shift and append.
  always_comb begin
    for (int i = 0; i < Depth - 1; i++) begin
      win_d[i] = release_c ? win_q[i+1] : win_q[i];
      if (accept_c && (wr_idx == IdxW'(i))) begin
        win_d[i] = in_item_i.in_byte;
      end
    end
    win_d[Depth-1] = win_q[Depth-1];
    if (accept_c && (wr_idx == IdxW'(Depth - 1))) begin
      win_d[Depth-1] = in_item_i.in_byte;
    end
  end

  // Count, flush and arming.
  always_comb begin
    count_d = count_q + CntW'(accept_c) - CntW'(release_c);
    flush_d = flush_q;
    if (accept_c && in_item_i.end_of_stream) begin
      flush_d = 1'b1;
    end else if (release_c && flush_q && (count_q == CntW'(1))) begin
      flush_d = 1'b0;
    end
    armed_d = accept_c ? 1'b1 : (armed_q && (count_d > len_c));
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flush_q <= 1'b0;
      armed_q <= 1'b0;
    end else begin
      count_q <= count_d;
      flush_q <= flush_d;
      armed_q <= armed_d;
    end
  end

  // Checks on the window control.
  `DSS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Depth),
                  "window count above depth")
  `DSS_ASSERT_IMP(a_flush_nonempty, clk_i, rst_ni, flush_q, count_q != '0,
                  "flush with empty window")
  `DSS_ASSERT_IMP(a_final_marked, clk_i, rst_ni,
                  flush_q && (count_q == CntW'(1)), rel_o.item.frame_last,
                  "final byte of stream not marked last")
  `DSS_ASSERT_NXT(a_flush_ends, clk_i, rst_ni,
                  release_c && flush_q && (count_q == CntW'(1)),
                  !flush_q && (count_q == '0), "flush did not end after final byte")

endmodule

### hdl/dss_out_reg.sv
// Output register of the delimiter stream splitter.
// Depends on dss_pkg; holds one result item for the receiver.
`timescale 1ns / 1ps

module dss_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dss_pkg::rel_t      rel_i,
  output logic               rel_take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dss_pkg::out_item_t out_item_o
);
  import dss_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;
  logic      load;

  // The register takes a new item when empty or being emptied.
  assign rel_take_o = !valid_q || out_ready_i;
  assign load       = rel_i.valid && rel_take_o;

  assign valid_d = load ? 1'b1 : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= rel_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

### verif/dss_frame_checker.sv
// Result checker for the delimiter stream splitter testbench.
// Watches the input, result and configuration channels; needs dss_pkg only.
`timescale 1ns / 1ps

module dss_frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  dss_pkg::in_item_t             in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  dss_pkg::out_item_t            out_item_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dss_pkg::PAT_W-1:0]     cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  import dss_pkg::*;

  localparam int HoldDepth = MAX_DELIM_DEF + 1;

  // Shadow copy of the registers and of the byte window, oldest byte first.
  logic [LEN_W-1:0]  delim_len = LEN_RESET;
  logic [PAT_W-1:0]  delim_pat = PAT_RESET;
  logic [BYTE_W-1:0] win_bytes [HoldDepth];
  int unsigned       win_cnt = 0;

  // Bytes the block still owes on its result channel, in order.
  out_item_t due_q [$];
  int        fails = 0;

  // True when a full delimiter starts right after the oldest held byte.
  function automatic bit delim_follows_oldest(input int unsigned len);
    if (win_cnt < len + 1) return 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      if (win_bytes[1 + i] != delim_pat[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Move the oldest held byte onto the list of owed results.
  task automatic emit_oldest(input bit last);
    due_q.push_back(out_item_t'{out_byte: win_bytes[0], frame_last: last});
    for (int i = 0; i < HoldDepth - 1; i++) begin
      win_bytes[i] = win_bytes[i + 1];
    end
    win_cnt--;
  endtask

  always @(posedge clk_i) begin : monitor
    int unsigned len;
    out_item_t   want;
    if (!rst_ni) begin
      delim_len = LEN_RESET;
      delim_pat = PAT_RESET;
      win_cnt   = 0;
      due_q.delete();
    end else begin
      // Register writes; unused indexes leave everything as it is.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DELIM_LENGTH:  delim_len = cfg_data_i[LEN_W-1:0];
          CFG_DELIM_PATTERN: delim_pat = cfg_data_i;
          default: ;
        endcase
      end

      // Each accepted item enters the window; bytes whose successors are
      // known leave it, marked when a delimiter starts right behind them.
      if (in_valid_i && in_ready_i) begin
        if (delim_len == 0) begin
          len = 1;
        end else if (delim_len > MAX_DELIM_DEF) begin
          len = MAX_DELIM_DEF;
        end else begin
          len = delim_len;
        end
        if (win_cnt >= HoldDepth) emit_oldest(delim_follows_oldest(len));
        win_bytes[win_cnt] = in_item_i.in_byte;
        win_cnt++;
        if (in_item_i.end_of_stream) begin
          // Flush: the final byte of the stream always closes its frame.
          while (win_cnt > 0) emit_oldest(win_cnt == 1 || delim_follows_oldest(len));
        end else begin
          while (win_cnt > len) emit_oldest(delim_follows_oldest(len));
        end
      end

      // Compare each result with the oldest owed byte.
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual byte %02h last %0b",
                   $time, out_item_i.out_byte, out_item_i.frame_last);
          fails++;
        end else begin
          want = due_q.pop_front();
          if (want.out_byte !== out_item_i.out_byte ||
              want.frame_last !== out_item_i.frame_last) begin
            $display("%0t: result mismatch: expected byte %02h last %0b, actual byte %02h last %0b",
                     $time, want.out_byte, want.frame_last,
                     out_item_i.out_byte, out_item_i.frame_last);
            fails++;
          end
        end
      end
    end
    pending_o    <= due_q.size();
    fail_count_o <= fails;
  end

endmodule

### verif/tb_top.sv
// Testbench top for the delimiter stream splitter: clock, reset, stimulus
// and verdict. Depends on dss_pkg, the block and dss_frame_checker.
`timescale 1ns / 1ps

module tb_top;

  import dss_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 16;
  localparam int RandItems   = 140;
  localparam int MinPhases   = 5;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAT_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;

  int src_idle_pct  = 12;
  int sink_idle_pct = 12;
  int sink_hold     = 0;
  int cycle_cnt;

  delimiter_stream_splitter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dss_frame_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: run stopped after %0d cycles", $time, cycle_cnt);
    $display("status: fail");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offer one byte, with a random gap before it, and wait for acceptance.
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic eos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= in_item_t'{in_byte: b, end_of_stream: eos};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending, wait for every owed result, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Length word with random junk above the four bits the block keeps.
  function automatic logic [PAT_W-1:0] len_word(input logic [LEN_W-1:0] l);
    logic [PAT_W-1:0] w;
    w = {$urandom(), $urandom()};
    w[LEN_W-1:0] = l;
    return w;
  endfunction

  initial begin
    logic [BYTE_W-1:0] d_bytes [$];
    logic [BYTE_W-1:0] gen_q [$];
    logic [LEN_W-1:0]  len_sel;
    logic [PAT_W-1:0]  pat;
    logic [BYTE_W-1:0] b;
    int unsigned       eff;
    int unsigned       n_pre;
    int                sel;
    int                target;
    int                rand_items;
    int                phase;
    bit                close_stream;
    bit                eos;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start code after reset: a match at the stream start is ignored, an
    // overlapping run of zeros still matches, and the flush finds a match
    // inside the held bytes.
    d_bytes = '{8'h00, 8'h00, 8'h01, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h01,
                8'h7E, 8'h00, 8'h00, 8'h01};
    foreach (d_bytes[i]) send_item(d_bytes[i], i == d_bytes.size() - 1);
    wait_idle();

    // Writes to unused indexes, then the length lowered while bytes are held.
    write_reg(CFG_SPARE_LO, {$urandom(), $urandom()});
    write_reg(CFG_SPARE_HI, {$urandom(), $urandom()});
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b0);
    send_item(8'h56, 1'b0);
    wait_idle();
    pat = {$urandom(), $urandom()};
    pat[7:0] = 8'h34;
    write_reg(CFG_DELIM_LENGTH, len_word(4'd0));
    write_reg(CFG_DELIM_PATTERN, pat);
    send_item(8'h34, 1'b0);
    send_item(8'h00, 1'b1);
    wait_idle();

    // Oversized length acts as the maximum; one flush releases a full window.
    write_reg(CFG_DELIM_LENGTH, len_word(4'd15));
    write_reg(CFG_DELIM_PATTERN, '1);
    for (int i = 0; i < MAX_DELIM_DEF + 1; i++) send_item(8'hFF, i == MAX_DELIM_DEF);
    wait_idle();

    // Random phases, each with its own delimiter setup. The first five
    // phases always run so that the stall and no-idle phases are covered.
    rand_items = 0;
    phase      = 0;
    while (rand_items < RandItems || phase < MinPhases) begin
      if (phase == 0) begin
        len_sel = 4'd1;
      end else if (phase == 1) begin
        len_sel = 4'd8;
      end else if ($urandom_range(99) < 20) begin
        len_sel = LEN_W'($urandom_range(0, 15));
      end else begin
        len_sel = LEN_W'($urandom_range(1, 8));
      end
      if (len_sel == 0) begin
        eff = 1;
      end else if (len_sel > MAX_DELIM_DEF) begin
        eff = MAX_DELIM_DEF;
      end else begin
        eff = len_sel;
      end

      // Random, two-symbol (self-overlapping), repeated-byte or start-code
      // style delimiters.
      pat = {$urandom(), $urandom()};
      sel = $urandom_range(3);
      case (sel)
        1: for (int i = 0; i < 8; i++) pat[8*i +: 8] = BYTE_W'($urandom_range(1));
        2: pat = {8{pat[7:0]}};
        3: pat[23:0] = 24'h010000;
        default: ;
      endcase
      write_reg(CFG_DELIM_LENGTH, len_word(len_sel));
      write_reg(CFG_DELIM_PATTERN, pat);

      // Phase two holds the receiver off so the window fills; phase four
      // runs without any idling.
      src_idle_pct  = (phase == 4) ? 0 : 12;
      sink_idle_pct = (phase == 4) ? 0 : 12;
      if (phase == 2) sink_hold = 100;
      target       = (phase == 2) ? 40 : $urandom_range(20, 36);
      close_stream = ($urandom_range(3) != 0);
      gen_q.delete();

      for (int n = 0; n < target; n++) begin
        // Streams are built mostly from whole delimiters, broken prefixes and
        // delimiter bytes, mixed with plain noise.
        if (gen_q.size() == 0) begin
          sel = $urandom_range(99);
          if (sel < 35) begin
            for (int i = 0; i < eff; i++) gen_q.push_back(pat[8*i +: 8]);
          end else if (sel < 50) begin
            n_pre = $urandom_range(0, eff - 1);
            for (int i = 0; i < n_pre; i++) gen_q.push_back(pat[8*i +: 8]);
            gen_q.push_back(BYTE_W'($urandom_range(255)));
          end else if (sel < 65) begin
            n_pre = $urandom_range(eff - 1);
            gen_q.push_back(pat[8*n_pre +: 8]);
          end else begin
            repeat ($urandom_range(1, 4)) gen_q.push_back(BYTE_W'($urandom_range(255)));
          end
        end
        b   = gen_q.pop_front();
        eos = (phase != 2 && $urandom_range(99) < 6) || (n == target - 1 && close_stream);
        send_item(b, eos);
        rand_items++;
      end
      wait_idle();
      phase++;
    end

    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
